>>> sv/fat12_pkg.sv
package fat12_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int ADDR_W = $clog2(MAX_ENTRIES);
	localparam int ENT_W = 12;
	localparam int LINK_W = ENT_W + 1;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [ENT_W-1:0] EOC_VALUE = 12'hFFF;
	localparam logic [ENT_W-1:0] END_MARK_MIN = 12'hFF8;
	localparam logic [ENT_W-1:0] TOP_USABLE = 12'hFF6;
	localparam logic [ENT_W-1:0] NO_LIMIT = 12'hFFF;
	localparam logic [ENT_W-1:0] FIRST_CLUSTER = 12'd2;
	localparam logic [ENT_W-1:0] TOP_MAX = ENT_W'(MAX_ENTRIES - 1);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_ENTRIES - 1);

	// register index as seen on paddr[CFG_ADDR_W-1:2]
	localparam logic [CFG_ADDR_W-3:0] REG_DATA_CLUSTERS = '0;

	typedef enum logic [1:0] {
		FN_READ,
		FN_WRITE,
		FN_ALLOC,
		FN_WALK
	} func_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_END,
		ST_FULL,
		ST_ERR
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_ALLOC,
		S_WALK,
		S_FIN
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ENT_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

>>> sv/fat12_ram.sv
module fat12_ram (
	input  logic                           clk,
	input  fat12_pkg::ram_req_t            req,
	output logic [fat12_pkg::ENT_W-1:0]    rdata
);
	import fat12_pkg::*;

	logic [ENT_W-1:0] mem [MAX_ENTRIES];
	logic [ENT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/fat12_regs.sv
module fat12_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fat12_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [fat12_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [fat12_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready,
	output logic [fat12_pkg::ENT_W-1:0]         data_clusters
);
	import fat12_pkg::*;

	logic [ENT_W-1:0] data_clusters_q;
	logic             sel_dc;

	assign sel_dc = (paddr[CFG_ADDR_W-1:2] == REG_DATA_CLUSTERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_clusters_q <= '0;
		end else if (psel && penable && pwrite && sel_dc) begin
			data_clusters_q <= pwdata[ENT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = sel_dc ? CFG_DATA_W'(data_clusters_q) : '0;
	assign data_clusters = data_clusters_q;

endmodule

>>> sv/fat12_seq.sv
module fat12_seq (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [fat12_pkg::ENT_W-1:0]      data_clusters,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic [fat12_pkg::ENT_W-1:0]      cluster,
	input  logic [fat12_pkg::ENT_W-1:0]      entry_value,
	input  logic [fat12_pkg::ENT_W-1:0]      step_limit,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fat12_pkg::ENT_W-1:0]      result_cluster,
	output logic [fat12_pkg::LINK_W-1:0]     links_followed,
	output logic [1:0]                       status,
	output fat12_pkg::ram_req_t              ram_req,
	input  logic [fat12_pkg::ENT_W-1:0]      ram_rdata
);
	import fat12_pkg::*;

	state_t state_q, state_d, go_state;

	logic [ADDR_W-1:0] clr_q;
	logic [ENT_W-1:0]  cur_q, cur_d;
	logic [ENT_W-1:0]  links_q, links_d, links_n;
	logic [ENT_W-1:0]  limit_q;
	logic              cur_ld;

	logic [ENT_W-1:0]  res_cl_q, res_ln_q;
	status_t           res_st_q;

	logic              out_valid_q;
	logic [ENT_W-1:0]  out_cl_q;
	logic [LINK_W-1:0] out_ln_q;
	status_t           out_st_q;

	logic              fin;
	logic [ENT_W-1:0]  fin_cl, fin_ln;
	status_t           fin_st;

	logic [ENT_W:0]    top_sum;
	logic [ENT_W-1:0]  top_c, max_links;
	logic              accept, out_free;

	function automatic logic valid_cl(input logic [ENT_W-1:0] c, input logic [ENT_W-1:0] t);
		return (c >= FIRST_CLUSTER) && (c <= t);
	endfunction

	// highest usable cluster, saturated to the table and below the marks
	assign top_sum = {1'b0, data_clusters} + (ENT_W + 1)'(1);
	always_comb begin
		top_c = TOP_MAX;
		if (top_sum < {1'b0, TOP_MAX}) begin
			top_c = top_sum[ENT_W-1:0];
		end
		if (top_c > TOP_USABLE) begin
			top_c = TOP_USABLE;
		end
	end
	assign max_links = top_c - FIRST_CLUSTER;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign links_n  = links_q + ENT_W'(1);

	// operation decode and memory requests
	always_comb begin
		fin      = 1'b0;
		fin_cl   = '0;
		fin_ln   = '0;
		fin_st   = ST_OK;
		go_state = state_q;
		cur_ld   = 1'b0;
		cur_d    = cur_q;
		links_d  = links_q;
		ram_req  = '0;
		case (state_q)
			S_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_q;
				ram_req.wdata = '0;
				go_state = (clr_q == CLR_LAST) ? S_IDLE : S_CLEAR;
			end
			S_IDLE: begin
				if (in_valid) begin
					case (func_t'(func))
						FN_READ: begin
							if (!valid_cl(cluster, top_c)) begin
								fin    = 1'b1;
								fin_st = ST_ERR;
							end else begin
								ram_req.re    = 1'b1;
								ram_req.raddr = cluster[ADDR_W-1:0];
								go_state = S_READ;
							end
						end
						FN_WRITE: begin
							fin = 1'b1;
							if (!valid_cl(cluster, top_c)) begin
								fin_st = ST_ERR;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = cluster[ADDR_W-1:0];
								ram_req.wdata = entry_value;
							end
						end
						FN_ALLOC: begin
							if (top_c < FIRST_CLUSTER) begin
								fin    = 1'b1;
								fin_st = ST_FULL;
							end else begin
								ram_req.re    = 1'b1;
								ram_req.raddr = FIRST_CLUSTER[ADDR_W-1:0];
								cur_ld   = 1'b1;
								cur_d    = FIRST_CLUSTER;
								go_state = S_ALLOC;
							end
						end
						FN_WALK: begin
							if (!valid_cl(cluster, top_c)) begin
								fin    = 1'b1;
								fin_st = ST_ERR;
							end else if (step_limit != NO_LIMIT && step_limit == '0) begin
								fin    = 1'b1;
								fin_cl = cluster;
							end else begin
								ram_req.re    = 1'b1;
								ram_req.raddr = cluster[ADDR_W-1:0];
								cur_ld   = 1'b1;
								cur_d    = cluster;
								links_d  = '0;
								go_state = S_WALK;
							end
						end
						default: begin
							fin    = 1'b1;
							fin_st = ST_ERR;
						end
					endcase
				end
			end
			S_READ: begin
				fin    = 1'b1;
				fin_cl = ram_rdata;
			end
			S_ALLOC: begin
				if (ram_rdata == '0) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = cur_q[ADDR_W-1:0];
					ram_req.wdata = EOC_VALUE;
					fin    = 1'b1;
					fin_cl = cur_q;
				end else if (cur_q == top_c) begin
					fin    = 1'b1;
					fin_st = ST_FULL;
				end else begin
					cur_ld        = 1'b1;
					cur_d         = cur_q + ENT_W'(1);
					ram_req.re    = 1'b1;
					ram_req.raddr = cur_d[ADDR_W-1:0];
				end
			end
			S_WALK: begin
				if (ram_rdata >= END_MARK_MIN) begin
					fin    = 1'b1;
					fin_cl = cur_q;
					fin_ln = links_q;
					fin_st = ST_END;
				end else if (!valid_cl(ram_rdata, top_c) || links_q >= max_links) begin
					fin    = 1'b1;
					fin_st = ST_ERR;
				end else if (limit_q != NO_LIMIT && links_n == limit_q) begin
					fin    = 1'b1;
					fin_cl = ram_rdata;
					fin_ln = links_n;
				end else begin
					cur_ld        = 1'b1;
					cur_d         = ram_rdata;
					links_d       = links_n;
					ram_req.re    = 1'b1;
					ram_req.raddr = ram_rdata[ADDR_W-1:0];
				end
			end
			S_FIN: begin
				fin    = 1'b1;
				fin_cl = res_cl_q;
				fin_ln = res_ln_q;
				fin_st = res_st_q;
			end
			default: begin
				go_state = S_IDLE;
			end
		endcase
	end

	// next state: a finished word parks in S_FIN while the output is full
	always_comb begin
		state_d = go_state;
		if (fin) begin
			state_d = out_free ? S_IDLE : S_FIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (fin && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= step_limit;
		end
		if (cur_ld) begin
			cur_q   <= cur_d;
			links_q <= links_d;
		end
		if (fin && out_free) begin
			out_cl_q <= fin_cl;
			out_ln_q <= LINK_W'(fin_ln);
			out_st_q <= fin_st;
		end else if (fin) begin
			res_cl_q <= fin_cl;
			res_ln_q <= fin_ln;
			res_st_q <= fin_st;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_cluster = out_cl_q;
	assign links_followed = out_ln_q;
	assign status         = out_st_q;

endmodule

>>> sv/fat12_allocation_table_engine.sv
// FAT12 allocation table engine.
// Input channel (in_valid/in_stall) takes one word per operation: func selects
// read entry, write entry, allocate the first free cluster, or walk a chain
// from cluster for at most step_limit links. The output channel
// (out_valid/out_stall) returns one word per operation: result_cluster,
// links_followed and status. data_clusters is set over the APB port; the user
// must set it only while idle, and the block itself does not enforce this.
// Steps per operation: a write, or any result settled without a table read,
// loads the output register at the edge that takes the input word when the
// output register is free; a read does one registered table read; allocate
// reads the entries one at a time from cluster 2 up to the free one; walk
// follows one link per table read. A new word is taken once the previous
// operation has finished. All table access goes through a single 4096 x 12
// synchronous RAM, one access per cycle. After reset the engine sweeps all
// 4096 table entries to zero, one entry a cycle, with in_stall high; APB
// writes are taken during the sweep. A stalled output word holds; one
// finished result may wait internally while the output register is full,
// and in_stall stays high until it moves on.
module fat12_allocation_table_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fat12_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [fat12_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [fat12_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic [fat12_pkg::ENT_W-1:0]         cluster,
	input  logic [fat12_pkg::ENT_W-1:0]         entry_value,
	input  logic [fat12_pkg::ENT_W-1:0]         step_limit,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [fat12_pkg::ENT_W-1:0]         result_cluster,
	output logic [fat12_pkg::LINK_W-1:0]        links_followed,
	output logic [1:0]                          status
);
	import fat12_pkg::*;

	logic [ENT_W-1:0] data_clusters;
	ram_req_t         ram_req;
	logic [ENT_W-1:0] ram_rdata;

	fat12_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.data_clusters (data_clusters)
	);

	fat12_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	fat12_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.data_clusters  (data_clusters),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.cluster        (cluster),
		.entry_value    (entry_value),
		.step_limit     (step_limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_cluster (result_cluster),
		.links_followed (links_followed),
		.status         (status),
		.ram_req        (ram_req),
		.ram_rdata      (ram_rdata)
	);

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr)
		else $error("table read and write hit the same entry");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> result_cluster == '0 && links_followed == '0)
		else $error("full result carries a cluster");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ERR |-> result_cluster == '0 && links_followed == '0)
		else $error("error result carries data");

endmodule
